// ===== hdl/fmh_pkg.sv =====
// Package: shared constants, codes and types for the FIFO handoff mutex.
`timescale 1ns / 1ps
package fmh_pkg;

   localparam int QUEUE_DEPTH_DEF     = 16;
   localparam int THREAD_ID_WIDTH_DEF = 8;
   localparam int STATUS_WIDTH        = 3;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STS_GRANTED   = 3'd0,
      STS_ALREADY   = 3'd1,
      STS_QUEUED    = 3'd2,
      STS_FREED     = 3'd3,
      STS_HANDOFF   = 3'd4,
      STS_NOT_OWNER = 3'd5,
      STS_FULL      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_READ,
      FSM_EXEC
   } fsm_state_type;

   typedef struct packed {
      logic load;    // capture the accepted transaction
      logic rd_en;   // read the head entry of the waiter queue
      logic exec;    // update lock state and load the response register
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;  // response register can take a new transaction
   } dp_stat_type;

endpackage

// ===== hdl/fmh_if.sv =====
// Interfaces: request and response channels of the FIFO handoff mutex.
`timescale 1ns / 1ps
interface fmh_req_if #(
   parameter int TW = fmh_pkg::THREAD_ID_WIDTH_DEF
);
   logic          valid;
   logic          ready;
   logic          cmd;
   logic [TW-1:0] thread_id;

   modport source (output valid, output cmd, output thread_id, input ready);
   modport sink   (input valid, input cmd, input thread_id, output ready);
endinterface

interface fmh_rsp_if #(
   parameter int TW = fmh_pkg::THREAD_ID_WIDTH_DEF,
   parameter int CW = $clog2(fmh_pkg::QUEUE_DEPTH_DEF + 1)
);
   logic                             valid;
   logic                             ready;
   logic [fmh_pkg::STATUS_WIDTH-1:0] status;
   logic                             wake_valid;
   logic [TW-1:0]                    wake_id;
   logic                             lock_held;
   logic [TW-1:0]                    owner_id;
   logic [CW-1:0]                    waiters;

   modport source (output valid, output status, output wake_valid, output wake_id,
                   output lock_held, output owner_id, output waiters, input ready);
   modport sink   (input valid, input status, input wake_valid, input wake_id,
                   input lock_held, input owner_id, input waiters, output ready);
endinterface

// ===== hdl/fifo_handoff_mutex.sv =====
// Top level: FIFO-ordered hardware mutex with direct ownership handoff.
`timescale 1ns / 1ps
// Usage:
//   req_chan carries one transaction per request: cmd (acquire or release)
//   and thread_id. rsp_chan returns exactly one response per request: status,
//   wake_valid/wake_id on handoff, and the lock state after the request
//   (lock_held, owner_id, waiters).
//   Each accepted request is captured, then the head of the waiter queue is
//   read from the registered queue memory, then the execute step updates the
//   lock state and loads the response register. A new request is taken only
//   after the previous one has finished its execute step.
//   The response register decouples the two sides: a new request is taken
//   while the previous response waits. If the receiver stalls, the response
//   holds and the next request waits in its execute step.
//   Reset (synchronous, active high) frees the lock, clears the owner and
//   empties the waiter queue; queue contents are not cleared and need no
//   clearing pass.
module fifo_handoff_mutex #(
   parameter int QUEUE_DEPTH     = fmh_pkg::QUEUE_DEPTH_DEF,
   parameter int THREAD_ID_WIDTH = fmh_pkg::THREAD_ID_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   fmh_req_if.sink   req_chan,
   fmh_rsp_if.source rsp_chan
);
   import fmh_pkg::*;

   ctl_cmd_type ctl;
   dp_stat_type stat;

   fmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   fmh_dp #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .THREAD_ID_WIDTH (THREAD_ID_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_cmd        (req_chan.cmd),
      .req_thread_id  (req_chan.thread_id),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_status     (rsp_chan.status),
      .rsp_wake_valid (rsp_chan.wake_valid),
      .rsp_wake_id    (rsp_chan.wake_id),
      .rsp_lock_held  (rsp_chan.lock_held),
      .rsp_owner_id   (rsp_chan.owner_id),
      .rsp_waiters    (rsp_chan.waiters)
   );
endmodule

// ===== hdl/fmh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module fmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/fmh_ctrl.sv =====
// Controller: sequences capture, queue read and execute of each transaction.
`timescale 1ns / 1ps
module fmh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fmh_pkg::dp_stat_type stat,
   output fmh_pkg::ctl_cmd_type ctl
);
   import fmh_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_READ;
         end
         FSM_READ: state_in = FSM_EXEC;
         FSM_EXEC: begin
            if (stat.out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         FSM_READ: ctl.rd_en = 1'b1;
         FSM_EXEC: ctl.exec = stat.out_free;
         default: ;
      endcase
   end
endmodule

// ===== hdl/fmh_dp.sv =====
// Datapath: lock state, waiter queue pointers and the response register.
`timescale 1ns / 1ps
module fmh_dp #(
   parameter int QUEUE_DEPTH     = fmh_pkg::QUEUE_DEPTH_DEF,
   parameter int THREAD_ID_WIDTH = fmh_pkg::THREAD_ID_WIDTH_DEF,
   parameter int QW              = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   parameter int CW              = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fmh_pkg::ctl_cmd_type        ctl,
   output fmh_pkg::dp_stat_type        stat,
   input  logic                        req_cmd,
   input  logic [THREAD_ID_WIDTH-1:0]  req_thread_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fmh_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic                        rsp_wake_valid,
   output logic [THREAD_ID_WIDTH-1:0]  rsp_wake_id,
   output logic                        rsp_lock_held,
   output logic [THREAD_ID_WIDTH-1:0]  rsp_owner_id,
   output logic [CW-1:0]               rsp_waiters
);
   import fmh_pkg::*;

   localparam int TW = THREAD_ID_WIDTH;

   logic          cmd_ff;
   logic [TW-1:0] tid_ff;
   logic          busy_ff, busy_in;
   logic [TW-1:0] owner_ff, owner_in;
   logic [QW-1:0] head_ff, head_in;
   logic [QW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   logic          wake_valid_ff, wake_valid_in;
   logic [TW-1:0] wake_id_ff, wake_id_in;
   logic          push;
   logic [TW-1:0] head_data;

   fmh_ram #(
      .WIDTH (TW),
      .DEPTH (QUEUE_DEPTH),
      .AW    (QW)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (tid_ff),
      .rd_en   (ctl.rd_en),
      .rd_addr (head_ff),
      .rd_data (head_data)
   );

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         tid_ff <= req_thread_id;
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      owner_in      = owner_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      wake_valid_in = 1'b0;
      wake_id_in    = '0;
      push          = 1'b0;
      if (cmd_ff == CMD_ACQUIRE) begin
         if (busy_ff && owner_ff == tid_ff) begin
            status_in = STS_ALREADY;
         end else if (!busy_ff) begin
            busy_in   = 1'b1;
            owner_in  = tid_ff;
            status_in = STS_GRANTED;
         end else if (count_ff == CW'(QUEUE_DEPTH)) begin
            status_in = STS_FULL;
         end else begin
            push      = ctl.exec;
            tail_in   = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            count_in  = count_ff + 1'b1;
            status_in = STS_QUEUED;
         end
      end else begin
         if (!busy_ff || owner_ff != tid_ff) begin
            status_in = STS_NOT_OWNER;
         end else if (count_ff != '0) begin
            owner_in      = head_data;
            head_in       = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in      = count_ff - 1'b1;
            wake_valid_in = 1'b1;
            wake_id_in    = head_data;
            status_in     = STS_HANDOFF;
         end else begin
            busy_in   = 1'b0;
            owner_in  = '0;
            status_in = STS_FREED;
         end
      end
   end

   always_comb begin
      if (ctl.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         owner_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.exec) begin
            busy_ff  <= busy_in;
            owner_ff <= owner_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         status_ff     <= status_in;
         wake_valid_ff <= wake_valid_in;
         wake_id_ff    <= wake_id_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_wake_valid = wake_valid_ff;
   assign rsp_wake_id    = wake_id_ff;
   assign rsp_lock_held  = busy_ff;
   assign rsp_owner_id   = owner_ff;
   assign rsp_waiters    = count_ff;
endmodule

// ===== hdl/fmh_checker.sv =====
// Checker: port-level assertions on the mutex response channel, bound to the top.
`timescale 1ns / 1ps
module fmh_checker #(
   parameter int QUEUE_DEPTH     = fmh_pkg::QUEUE_DEPTH_DEF,
   parameter int THREAD_ID_WIDTH = fmh_pkg::THREAD_ID_WIDTH_DEF,
   parameter int CW              = $clog2(QUEUE_DEPTH + 1)
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [fmh_pkg::STATUS_WIDTH-1:0] rsp_status,
   input logic                       rsp_wake_valid,
   input logic                       rsp_lock_held,
   input logic [THREAD_ID_WIDTH-1:0] rsp_owner_id,
   input logic [CW-1:0]              rsp_waiters
);
   import fmh_pkg::*;

   a_wake_on_handoff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wake_valid == (rsp_status == STS_HANDOFF)))
      else $error("wake_valid does not match handoff status");

   a_free_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_lock_held) |-> (rsp_owner_id == '0 && rsp_waiters == '0))
      else $error("free lock reports owner or waiters");

   a_freed_not_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_FREED) |-> !rsp_lock_held)
      else $error("freed status with lock still held");

   a_waiters_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_waiters <= CW'(QUEUE_DEPTH)))
      else $error("waiter count beyond queue depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");
endmodule

bind fifo_handoff_mutex fmh_checker #(
   .QUEUE_DEPTH     (QUEUE_DEPTH),
   .THREAD_ID_WIDTH (THREAD_ID_WIDTH)
) u_fmh_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_wake_valid (rsp_chan.wake_valid),
   .rsp_lock_held  (rsp_chan.lock_held),
   .rsp_owner_id   (rsp_chan.owner_id),
   .rsp_waiters    (rsp_chan.waiters)
);
